[sv/dse_pkg.sv]
`timescale 1ns / 1ps
package dse_pkg;
  typedef enum logic [1:0] {
    REQ_RECORD = 2'd0,
    REQ_LEVEL = 2'd1,
    REQ_ESTIMATE = 2'd2,
    REQ_CLEAR = 2'd3
  } req_type_t;

  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 24;
  localparam logic [CFG_IDX_W-1:0] CFG_COLD_DEFAULT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLD_HEADROOM = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ADAPT_HEADROOM = 2'd2;

  localparam logic [23:0] CNT_MAX = 24'hFFFFFF;

  // packed slot: count 24, sum 40, sumsq 56, largest request 16, largest level 24
  typedef struct packed {
    logic [23:0] cnt;
    logic [39:0] sum;
    logic [55:0] sq;
    logic [15:0] lreq;
    logic [23:0] llvl;
  } slot_t;

  typedef struct packed {
    logic [23:0] n;
    logic [39:0] sum;
    logic [55:0] sq;
    logic [15:0] lreq;
    logic [23:0] llvl;
    logic [13:0] k;
    logic [15:0] adapt_hr;
  } est_req_t;
endpackage

[sv/dse_if.sv]
`timescale 1ns / 1ps
interface dse_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [3:0]  agent_index;
  logic [2:0]  resource_index;
  logic [15:0] request_amount;
  logic [23:0] allocation_level;
  logic [13:0] sigma_multiplier;
  modport source(output valid, req_type, agent_index, resource_index, request_amount,
                 allocation_level, sigma_multiplier, input ready);
  modport sink(input valid, req_type, agent_index, resource_index, request_amount,
               allocation_level, sigma_multiplier, output ready);
endinterface

interface dse_out_if;
  logic        valid;
  logic        ready;
  logic [23:0] estimate;
  modport source(output valid, estimate, input ready);
  modport sink(input valid, estimate, output ready);
endinterface

[sv/dse_mul.sv]
`timescale 1ns / 1ps
// Sequential 64x64 -> 128 multiplier, 16 bits of b per cycle.
module dse_mul (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [63:0]  a,
  input  logic [63:0]  b,
  output logic         done,
  output logic [127:0] p
);
  logic [63:0]  a_r, b_r;
  logic [127:0] acc_r;
  logic [2:0]   cnt_r;
  logic         busy_r;
  logic [79:0]  part;

  // 64x16 partial product of a and the low 16 bits of b
  assign part = {16'd0, a_r} * {64'd0, b_r[15:0]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done   <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        a_r    <= a;
        b_r    <= b;
        acc_r  <= '0;
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        acc_r <= acc_r + ({48'd0, part} << {cnt_r[1:0], 4'd0});
        b_r   <= b_r >> 16;
        cnt_r <= cnt_r + 3'd1;
        if (cnt_r == 3'd3) begin
          busy_r <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end
  assign p = acc_r;
endmodule

[sv/dse_estimate.sv]
`timescale 1ns / 1ps
// Estimate for a slot with two or more samples: variance divide, isqrt,
// mean divide, k*sd, floor, cap, ceil. Sequencer over one shared multiplier.
module dse_estimate (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  dse_pkg::est_req_t   req,
  output logic                done,
  output logic [23:0]         result
);
  import dse_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_M1, S_M1W, S_M2, S_M2W, S_NN, S_NNW, S_DIV, S_SQ, S_MDIV,
    S_KM, S_KMW, S_CAP, S_CAPW, S_FIN
  } st_t;

  st_t          st_r;
  est_req_t     q_r;
  logic         m_start;
  logic [63:0]  m_a, m_b;
  logic         m_done;
  logic [127:0] m_p;
  logic [127:0] nsq_r;
  logic [143:0] num_r;
  logic [63:0]  d_r, rem_r, quo_r;
  logic [7:0]   i_r;
  logic [63:0]  sx_r, sres_r, sbit_r;
  logic [63:0]  mrem_r, mquo_r;
  logic [63:0]  est_r;
  logic [64:0]  rem_sh;
  logic [64:0]  mrem_sh;
  logic [59:0]  mean_num;
  logic [63:0]  sq_try;
  logic [63:0]  lreq_q;
  logic [64:0]  est_ceil;

  dse_mul u_mul (
    .clk(clk), .rst_n(rst_n), .start(m_start), .a(m_a), .b(m_b), .done(m_done), .p(m_p)
  );

  assign rem_sh   = {rem_r, num_r[143]};
  assign mean_num = {q_r.sum, 20'd0};
  assign mrem_sh  = {mrem_r, mean_num[59]};
  assign sq_try   = sres_r + sbit_r;
  assign lreq_q   = {28'd0, q_r.lreq, 20'd0};
  assign est_ceil = {1'b0, est_r} + 65'hFFFFF;

  always_comb begin
    m_start = 1'b0;
    m_a = '0;
    m_b = '0;
    case (st_r)
      S_M1: begin
        m_start = 1'b1; m_a = {40'd0, q_r.n}; m_b = {8'd0, q_r.sq};
      end
      S_M2: begin
        m_start = 1'b1; m_a = {24'd0, q_r.sum}; m_b = {24'd0, q_r.sum};
      end
      S_NN: begin
        m_start = 1'b1; m_a = {40'd0, q_r.n}; m_b = {40'd0, q_r.n - 24'd1};
      end
      S_KM: begin
        m_start = 1'b1; m_a = {50'd0, q_r.k}; m_b = sres_r;
      end
      S_CAP: begin
        m_start = 1'b1; m_a = {40'd0, q_r.llvl}; m_b = {48'd0, q_r.adapt_hr};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      case (st_r)
        S_IDLE: if (start) begin
          q_r  <= req;
          st_r <= S_M1;
        end
        S_M1: st_r <= S_M1W;
        S_M1W: if (m_done) begin
          nsq_r <= m_p;
          st_r  <= S_M2;
        end
        S_M2: st_r <= S_M2W;
        S_M2W: if (m_done) begin
          if (nsq_r < m_p) num_r <= '0;
          else num_r <= {16'd0, nsq_r - m_p} << 16;
          st_r <= S_NN;
        end
        S_NN: st_r <= S_NNW;
        S_NNW: if (m_done) begin
          d_r   <= m_p[63:0];
          rem_r <= '0;
          quo_r <= '0;
          i_r   <= 8'd0;
          st_r  <= S_DIV;
        end
        S_DIV: begin
          // one quotient bit per cycle over the 144-bit numerator (num top 16 bits are zero)
          num_r <= num_r << 1;
          if (rem_sh >= {1'b0, d_r}) begin
            rem_r <= 64'(rem_sh - {1'b0, d_r});
            quo_r <= {quo_r[62:0], 1'b1};
          end else begin
            rem_r <= rem_sh[63:0];
            quo_r <= {quo_r[62:0], 1'b0};
          end
          if (i_r == 8'd143) begin
            st_r   <= S_SQ;
            sbit_r <= 64'h4000_0000_0000_0000;
            sres_r <= '0;
          end
          i_r <= i_r + 8'd1;
          if (i_r == 8'd143) sx_r <= (rem_sh >= {1'b0, d_r}) ? {quo_r[62:0], 1'b1}
                                                               : {quo_r[62:0], 1'b0};
        end
        S_SQ: begin
          if (sbit_r == 64'd0) begin
            st_r   <= S_MDIV;
            mrem_r <= '0;
            mquo_r <= '0;
            i_r    <= 8'd0;
            q_r.sum <= q_r.sum;
          end else begin
            if (sx_r >= sq_try) begin
              sx_r   <= sx_r - sq_try;
              sres_r <= (sres_r >> 1) + sbit_r;
            end else begin
              sres_r <= sres_r >> 1;
            end
            sbit_r <= sbit_r >> 2;
          end
        end
        S_MDIV: begin
          // (sum<<20)/n, bit-serial over the 60-bit numerator; shift the numerator through q_r.sum
          if (mrem_sh >= {41'd0, q_r.n}) begin
            mrem_r <= 64'(mrem_sh - {41'd0, q_r.n});
            mquo_r <= {mquo_r[62:0], 1'b1};
          end else begin
            mrem_r <= mrem_sh[63:0];
            mquo_r <= {mquo_r[62:0], 1'b0};
          end
          q_r.sum <= {q_r.sum[38:0], 1'b0};
          // after 40 shifts of sum the low 20 zero bits follow automatically
          i_r <= i_r + 8'd1;
          if (i_r == 8'd59) st_r <= S_KM;
        end
        S_KM: st_r <= S_KMW;
        S_KMW: if (m_done) begin
          est_r <= mquo_r + m_p[63:0];
          st_r  <= S_CAP;
        end
        S_CAP: begin
          if (est_r < lreq_q) est_r <= lreq_q;
          st_r <= S_CAPW;
        end
        S_CAPW: if (m_done) begin
          if (q_r.llvl != 24'd0 && est_r > {m_p[51:0], 12'd0}) est_r <= {m_p[51:0], 12'd0};
          st_r <= S_FIN;
        end
        S_FIN: begin
          if (est_ceil[64:20] > 45'hFFFFFF) result <= 24'hFFFFFF;
          else if (est_ceil[64:20] == 45'd0) result <= 24'd1;
          else result <= est_ceil[43:20];
          done <= 1'b1;
          st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  property p_done_from_fin;
    @(posedge clk) disable iff (!rst_n) done |-> $past(st_r) == S_FIN;
  endproperty
  a_done_from_fin: assert property (p_done_from_fin) else $error("done without finish");

  property p_mul_idle;
    @(posedge clk) disable iff (!rst_n) m_start |=> !m_start;
  endproperty
  a_mul_idle: assert property (p_mul_idle) else $error("back to back multiply");

  property p_start_idle;
    @(posedge clk) disable iff (!rst_n) start |-> st_r == S_IDLE;
  endproperty
  a_start_idle: assert property (p_start_idle) else $error("start while busy");
endmodule

[sv/demand_stats_estimator_core.sv]
`timescale 1ns / 1ps
// channel | dir | payload
// in      | in  | req_type, agent_index, resource_index, request_amount,
//         |     | allocation_level, sigma_multiplier
// out     | out | estimate
// cfg     | in  | cfg_we, cfg_index, cfg_wdata
// Record and level items go through accept, read, then modify and write back.
// An estimate of a slot with two or more samples runs the 144-step bit-serial
// variance divide, the bit-serial isqrt, the 60-step mean divide and five
// multiplies on a single sequential multiplier.
// Clear walks the agent's NUM_RESOURCES slots, one a cycle.
// After reset a clearing pass over all NUM_AGENTS*NUM_RESOURCES slots runs; in.ready is low.
// One item at a time; in.ready stays low while a result waits on out.
module demand_stats_estimator_core #(
  parameter int NUM_AGENTS    = 16,
  parameter int NUM_RESOURCES = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  dse_in_if.sink                         in_ch,
  dse_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [dse_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dse_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import dse_pkg::*;

  localparam int SLOTS = NUM_AGENTS * NUM_RESOURCES;
  localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int RW = (NUM_RESOURCES > 1) ? $clog2(NUM_RESOURCES) : 1;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_RD, S_MOD, S_CLR, S_EST, S_EWAIT, S_OUT
  } st_t;

  st_t         st_r;
  slot_t       mem [SLOTS];
  slot_t       rd_r;
  logic [AW-1:0] addr_r;
  logic [AW:0]   init_r;
  logic [RW:0]   clr_r;
  logic        we;
  logic [AW-1:0] waddr;
  slot_t       wdata;
  logic [1:0]  type_r;
  logic [15:0] amt_r;
  logic [23:0] lvl_r;
  logic [13:0] k_r;
  logic [23:0] cold_def_r;
  logic [15:0] cold_hr_r, adapt_hr_r;
  logic [23:0] est_r;
  logic        out_v_r;
  logic        e_start, e_done;
  logic [23:0] e_res;
  est_req_t    e_req;
  logic        valid_addr;
  logic [31:0] slot_idx;
  logic [31:0] one_mul;
  logic [32:0] one_ceil;

  assign slot_idx = 32'(in_ch.agent_index) * 32'(NUM_RESOURCES) + 32'(in_ch.resource_index);
  assign valid_addr = (32'(in_ch.agent_index) < 32'(NUM_AGENTS)) &&
                      (32'(in_ch.resource_index) < 32'(NUM_RESOURCES));

  assign in_ch.ready  = (st_r == S_IDLE);
  assign out_ch.valid = out_v_r;
  assign out_ch.estimate = est_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cold_def_r <= 24'd1;
      cold_hr_r  <= 16'd512;
      adapt_hr_r <= 16'd384;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_COLD_DEFAULT:   cold_def_r <= cfg_wdata;
        CFG_COLD_HEADROOM:  cold_hr_r  <= cfg_wdata[15:0];
        CFG_ADAPT_HEADROOM: adapt_hr_r <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rd_r <= mem[addr_r];
  end

  assign one_mul  = 32'(rd_r.lreq) * 32'(cold_hr_r);
  assign one_ceil = {1'b0, one_mul} + 33'd255;

  always_comb begin
    we = 1'b0;
    waddr = addr_r;
    wdata = rd_r;
    case (st_r)
      S_INIT: begin
        we = 1'b1; waddr = init_r[AW-1:0]; wdata = '0;
      end
      S_CLR: begin
        we = 1'b1; wdata = '0;
      end
      S_MOD: begin
        if (type_r == REQ_RECORD) begin
          we = 1'b1;
          if (rd_r.cnt != CNT_MAX) begin
            wdata.cnt = rd_r.cnt + 24'd1;
            wdata.sum = rd_r.sum + {24'd0, amt_r};
            wdata.sq  = rd_r.sq + {24'd0, 32'(amt_r) * 32'(amt_r)};
          end
          if (amt_r > rd_r.lreq) wdata.lreq = amt_r;
        end else if (type_r == REQ_LEVEL) begin
          we = 1'b1;
          if (lvl_r > rd_r.llvl) wdata.llvl = lvl_r;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    e_req.n = rd_r.cnt;
    e_req.sum = rd_r.sum;
    e_req.sq = rd_r.sq;
    e_req.lreq = rd_r.lreq;
    e_req.llvl = rd_r.llvl;
    e_req.k = k_r;
    e_req.adapt_hr = adapt_hr_r;
  end
  assign e_start = (st_r == S_EST) && (rd_r.cnt > 24'd1);

  dse_estimate u_est (
    .clk(clk), .rst_n(rst_n), .start(e_start), .req(e_req), .done(e_done), .result(e_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= S_INIT;
      init_r  <= '0;
      out_v_r <= 1'b0;
      addr_r  <= '0;
    end else begin
      case (st_r)
        S_INIT: begin
          init_r <= init_r + (AW+1)'(1);
          if (init_r == (AW+1)'(SLOTS - 1)) st_r <= S_IDLE;
        end
        S_IDLE: if (in_ch.valid) begin
          type_r <= in_ch.req_type;
          amt_r  <= in_ch.request_amount;
          lvl_r  <= in_ch.allocation_level;
          k_r    <= in_ch.sigma_multiplier;
          addr_r <= slot_idx[AW-1:0];
          case (req_type_t'(in_ch.req_type))
            REQ_RECORD, REQ_LEVEL: if (valid_addr) st_r <= S_RD;
            REQ_ESTIMATE: begin
              if (valid_addr) st_r <= S_RD;
              else begin
                est_r <= cold_def_r; out_v_r <= 1'b1; st_r <= S_OUT;
              end
            end
            REQ_CLEAR: if (32'(in_ch.agent_index) < 32'(NUM_AGENTS)) begin
              addr_r <= AW'(32'(in_ch.agent_index) * 32'(NUM_RESOURCES));
              clr_r  <= '0;
              st_r   <= S_CLR;
            end
            default: ;
          endcase
        end
        S_RD: st_r <= (type_r == REQ_ESTIMATE) ? S_EST : S_MOD;
        S_MOD: st_r <= S_IDLE;
        S_CLR: begin
          addr_r <= addr_r + AW'(1);
          clr_r  <= clr_r + (RW+1)'(1);
          if (clr_r == (RW+1)'(NUM_RESOURCES - 1)) st_r <= S_IDLE;
        end
        S_EST: begin
          if (rd_r.cnt == 24'd0) begin
            est_r <= cold_def_r; out_v_r <= 1'b1; st_r <= S_OUT;
          end else if (rd_r.cnt == 24'd1) begin
            if (one_ceil[32:8] > 25'hFFFFFF) est_r <= 24'hFFFFFF;
            else if (one_ceil[32:8] == 25'd0) est_r <= 24'd1;
            else est_r <= one_ceil[31:8];
            out_v_r <= 1'b1;
            st_r <= S_OUT;
          end else st_r <= S_EWAIT;
        end
        S_EWAIT: if (e_done) begin
          est_r <= e_res; out_v_r <= 1'b1; st_r <= S_OUT;
        end
        S_OUT: if (out_ch.ready) begin
          out_v_r <= 1'b0; st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  property p_out_only_in_out;
    @(posedge clk) disable iff (!rst_n) out_v_r |-> st_r == S_OUT;
  endproperty
  a_out_only_in_out: assert property (p_out_only_in_out) else $error("stray result");

  property p_no_accept_busy;
    @(posedge clk) disable iff (!rst_n) in_ch.ready |-> !out_v_r;
  endproperty
  a_no_accept_busy: assert property (p_no_accept_busy) else $error("ready while result held");

  property p_est_done;
    @(posedge clk) disable iff (!rst_n) e_done |-> st_r == S_EWAIT;
  endproperty
  a_est_done: assert property (p_est_done) else $error("estimate done unexpectedly");
endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
module tb;
  import dse_pkg::*;

  typedef struct {
    req_type_t   kind;
    logic [3:0]  agent;
    logic [2:0]  rsrc;
    logic [15:0] amount;
    logic [23:0] level;
    logic [13:0] k;
  } demand_word_t;

  // per-slot statistics and the three registers, kept alongside the block
  class demand_scoreboard;
    logic [23:0] cnt[128];
    logic [39:0] sum[128];
    logic [55:0] sq[128];
    logic [15:0] lreq[128];
    logic [23:0] llvl[128];
    logic [23:0] cold_default;
    logic [15:0] cold_hr;
    logic [15:0] adapt_hr;
    logic [23:0] pending_estimates[$];
    int errors;
    int checked;

    function new();
      cold_default = 24'd1;
      cold_hr = 16'd512;
      adapt_hr = 16'd384;
      errors = 0;
      checked = 0;
      for (int i = 0; i < 128; i++) begin
        cnt[i] = '0; sum[i] = '0; sq[i] = '0; lreq[i] = '0; llvl[i] = '0;
      end
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [23:0] val);
      case (idx)
        CFG_COLD_DEFAULT:   cold_default = val;
        CFG_COLD_HEADROOM:  cold_hr = val[15:0];
        CFG_ADAPT_HEADROOM: adapt_hr = val[15:0];
        default: ;
      endcase
    endfunction

    function logic [63:0] int_sqrt(logic [63:0] x);
      logic [63:0] res;
      logic [63:0] b;
      res = '0;
      b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
        if (x >= res + b) begin
          x = x - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
      return res;
    endfunction

    function logic [23:0] slot_estimate(int s, logic [13:0] k);
      logic [127:0] a;
      logic [127:0] b;
      logic [127:0] num;
      logic [127:0] quo;
      logic [63:0] n;
      logic [63:0] d;
      logic [63:0] est;
      logic [63:0] cap;
      logic [63:0] r;
      n = {40'd0, cnt[s]};
      if (n == 0) return cold_default;
      if (n == 1) begin
        r = ({48'd0, lreq[s]} * {48'd0, cold_hr} + 64'd255) >> 8;
        if (r > 64'hFFFFFF) r = 64'hFFFFFF;
        return (r == 0) ? 24'd1 : r[23:0];
      end
      a = {104'd0, cnt[s]} * {72'd0, sq[s]};
      b = {88'd0, sum[s]} * {88'd0, sum[s]};
      num = (a < b) ? '0 : a - b;
      num = num << 16;
      d = n * (n - 64'd1);
      quo = num / {64'd0, d};
      est = (({24'd0, sum[s]} << 20) / n) + {50'd0, k} * int_sqrt(quo[63:0]);
      if (est < ({48'd0, lreq[s]} << 20)) est = {48'd0, lreq[s]} << 20;
      if (llvl[s] != 0) begin
        cap = ({40'd0, llvl[s]} * {48'd0, adapt_hr}) << 12;
        if (est > cap) est = cap;
      end
      r = (est + 64'hFFFFF) >> 20;
      if (r > 64'hFFFFFF) r = 64'hFFFFFF;
      return (r == 0) ? 24'd1 : r[23:0];
    endfunction

    function void note_word(demand_word_t w);
      int s;
      s = w.agent * 8 + w.rsrc;
      case (w.kind)
        REQ_RECORD: begin
          if (cnt[s] < CNT_MAX) begin
            cnt[s] = cnt[s] + 24'd1;
            sum[s] = sum[s] + {24'd0, w.amount};
            sq[s] = sq[s] + {40'd0, w.amount} * {40'd0, w.amount};
          end
          if (w.amount > lreq[s]) lreq[s] = w.amount;
        end
        REQ_LEVEL: if (w.level > llvl[s]) llvl[s] = w.level;
        REQ_ESTIMATE: pending_estimates.push_back(slot_estimate(s, w.k));
        REQ_CLEAR: begin
          for (int r = 0; r < 8; r++) begin
            cnt[w.agent*8+r] = '0; sum[w.agent*8+r] = '0; sq[w.agent*8+r] = '0;
            lreq[w.agent*8+r] = '0; llvl[w.agent*8+r] = '0;
          end
        end
        default: ;
      endcase
    endfunction

    function void check_estimate(logic [23:0] got);
      logic [23:0] want;
      if (pending_estimates.size() == 0) begin
        $error("estimate: unexpected word, actual %0d", got);
        errors++;
        return;
      end
      want = pending_estimates.pop_front();
      checked++;
      if (got !== want) begin
        $error("estimate: expected %0d, actual %0d", want, got);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  dse_in_if in_ch();
  dse_out_if out_ch();

  demand_stats_estimator_core dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  demand_scoreboard sb;
  bit steady;  // no idling on either side while set
  int words_sent;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.req_type = '0;
    in_ch.agent_index = '0;
    in_ch.resource_index = '0;
    in_ch.request_amount = '0;
    in_ch.allocation_level = '0;
    in_ch.sigma_multiplier = '0;
    out_ch.ready = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst_n) out_ch.ready <= 1'b0;
    else out_ch.ready <= steady || ($urandom_range(0, 99) >= 28);
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) sb.check_estimate(out_ch.estimate);
  end

  task automatic send_word(demand_word_t w);
    if (!steady && $urandom_range(0, 99) < 28) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.req_type <= w.kind;
    in_ch.agent_index <= w.agent;
    in_ch.resource_index <= w.rsrc;
    in_ch.request_amount <= w.amount;
    in_ch.allocation_level <= w.level;
    in_ch.sigma_multiplier <= w.k;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_word(w);
    words_sent++;
  endtask

  task automatic send(req_type_t kind, int agent, int rsrc, int amount, int level, int k);
    demand_word_t w;
    w.kind = kind;
    w.agent = 4'(agent);
    w.rsrc = 3'(rsrc);
    w.amount = 16'(amount);
    w.level = 24'(level);
    w.k = 14'(k);
    send_word(w);
  endtask

  // drain results, then leave time for a record or clear still in flight
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_estimates.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [23:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(idx, val);
  endtask

  function automatic demand_word_t random_word();
    demand_word_t w;
    int p;
    p = $urandom_range(0, 99);
    w.kind = (p < 45) ? REQ_RECORD : (p < 60) ? REQ_LEVEL : (p < 95) ? REQ_ESTIMATE : REQ_CLEAR;
    // mostly a few hot slots so that sample counts grow
    w.agent = 4'(($urandom_range(0, 99) < 75) ? $urandom_range(0, 3) : $urandom_range(0, 15));
    w.rsrc = 3'(($urandom_range(0, 99) < 75) ? $urandom_range(0, 1) : $urandom_range(0, 7));
    p = $urandom_range(0, 99);
    w.amount = 16'((p < 50) ? $urandom_range(0, 300) :
                   (p < 80) ? $urandom : $urandom_range(900, 1100));
    p = $urandom_range(0, 99);
    w.level = 24'((p < 20) ? 0 : (p < 60) ? $urandom_range(0, 2000) : $urandom);
    w.k = 14'(($urandom_range(0, 3) == 0) ? 4096 : $urandom);
    return w;
  endfunction

  task automatic random_phase(int count);
    for (int i = 0; i < count; i++) send_word(random_word());
  endtask

  initial begin
    sb = new();
    steady = 1'b0;
    words_sent = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty slot, one sample, extremes, caps and clear
    send(REQ_ESTIMATE, 0, 0, 0, 0, 0);
    send(REQ_RECORD, 0, 0, 65535, 0, 0);
    send(REQ_ESTIMATE, 0, 0, 0, 0, 16383);
    send(REQ_RECORD, 0, 0, 0, 0, 0);
    send(REQ_ESTIMATE, 0, 0, 0, 0, 16383);
    send(REQ_LEVEL, 0, 0, 0, 24'hFFFFFF, 0);
    send(REQ_ESTIMATE, 0, 0, 0, 0, 0);
    send(REQ_RECORD, 15, 7, 10, 0, 0);
    send(REQ_RECORD, 15, 7, 30, 0, 0);
    send(REQ_LEVEL, 15, 7, 0, 1, 0);
    send(REQ_ESTIMATE, 15, 7, 0, 0, 16383);
    send(REQ_CLEAR, 15, 5, 0, 0, 0);
    send(REQ_ESTIMATE, 15, 7, 0, 0, 100);
    send(REQ_RECORD, 1, 0, 0, 0, 0);
    send(REQ_ESTIMATE, 1, 0, 0, 0, 0);
    drain();

    write_reg(CFG_COLD_DEFAULT, 24'd0);
    write_reg(CFG_COLD_HEADROOM, 24'd0);
    write_reg(CFG_ADAPT_HEADROOM, 24'd0);
    send(REQ_ESTIMATE, 2, 3, 0, 0, 0);
    send(REQ_RECORD, 2, 3, 500, 0, 0);
    send(REQ_ESTIMATE, 2, 3, 0, 0, 0);
    send(REQ_RECORD, 2, 3, 700, 0, 0);
    send(REQ_LEVEL, 2, 3, 0, 1000, 0);
    send(REQ_ESTIMATE, 2, 3, 0, 0, 8191);
    random_phase(150);
    drain();

    write_reg(CFG_COLD_DEFAULT, 24'hFFFFFF);
    write_reg(CFG_COLD_HEADROOM, 24'hFFFF);
    write_reg(CFG_ADAPT_HEADROOM, 24'hFFFF);
    send(REQ_ESTIMATE, 9, 6, 0, 0, 0);
    steady = 1'b1;
    random_phase(150);
    steady = 1'b0;
    drain();

    write_reg(CFG_COLD_DEFAULT, 24'd1);
    write_reg(CFG_COLD_HEADROOM, 24'd512);
    write_reg(CFG_ADAPT_HEADROOM, 24'd384);
    random_phase(150);
    drain();

    write_reg(CFG_COLD_DEFAULT, 24'($urandom));
    write_reg(CFG_COLD_HEADROOM, 24'($urandom_range(0, 65535)));
    write_reg(CFG_ADAPT_HEADROOM, 24'($urandom_range(0, 65535)));
    random_phase(150);
    drain();
    repeat (300) @(posedge clk);

    $display("Sent %0d words across five register settings, zero and full headroom included.",
             words_sent);
    $display("Compared %0d estimates, %0d mismatches.", sb.checked, sb.errors);
    if (sb.errors == 0 && sb.pending_estimates.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("CHECKS FAILED");
    $finish;
  end
endmodule
